@@ hw/rtl/fmiq_pkg.sv @@
// ----------------------------------------------------------------------------
// fmiq_pkg
// Shared constants, types and functions of the FM I/Q modulator.
// ----------------------------------------------------------------------------
package fmiq_pkg;

	localparam int PHASE_BITS_DEF     = 32;
	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int SINE_ADDR_BITS_DEF = 12;

	// accumulator slice width of one carry cell
	localparam int CELL_W = 8;

	localparam int STEP_W = 32;
	localparam int DEV_W  = 16;
	localparam int GAIN_W = 16;
	localparam int OFS_W  = 32;
	localparam int SINE_W = 16;
	localparam int OUT_W  = 16;
	localparam int GP_W   = GAIN_W + SINE_W;
	localparam int RS_W   = GP_W + 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CARRIER_STEP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_I_GAIN          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Q_GAIN          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET    = 3'd4;

	localparam logic [STEP_W-1:0] CARRIER_STEP_RST = '0;
	localparam logic [DEV_W-1:0]  DEV_SCALE_RST    = '0;
	localparam logic [GAIN_W-1:0] GAIN_RST         = 16'd32768;
	localparam logic [OFS_W-1:0]  PHASE_OFFSET_RST = 32'h4000_0000;

	localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
	localparam logic [63:0] ONE_Q31     = 64'd1 << 31;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_ACC,
		ST_ADDR,
		ST_ROM,
		ST_MUL,
		ST_OUT
	} fmiq_state_t;

	// round(32767 * sin(pi/2 * j / 2^quad_bits)), Taylor series through x^13
	function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] j,
			input int unsigned quad_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] e;
		int n;
		x  = (HALF_PI_Q31 * j) >> quad_bits;
		x2 = (x * x) >> 31;
		t  = ONE_Q31;
		for (n = 0; n < 6; n++) begin
			t = ONE_Q31 - (((x2 * t) >> 31) / TAYLOR_DIV[n]);
		end
		s = (x * t) >> 31;
		e = (64'd32767 * s + (64'd1 << 30)) >> 31;
		return e[SINE_W-1:0];
	endfunction

	// p / 2^15 rounded half up, saturated to Q1.15
	function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [RS_W-1:0] p);
		logic signed [RS_W-1:0] r;
		r = (p + RS_W'(16384)) >>> 15;
		if (r > RS_W'(32767)) begin
			return 16'sh7FFF;
		end else if (r < -RS_W'(32768)) begin
			return 16'sh8000;
		end
		return r[OUT_W-1:0];
	endfunction

endpackage

@@ hw/rtl/fm_iq_modulator_top.sv @@
// ----------------------------------------------------------------------------
// fm_iq_modulator_top
// Each input passes the increment, the carry ripple through NCELLS =
// ceil(PHASE_BITS/8) carry cells, address, ROM, multiply and output states.
// One item in flight: no new input until the result is loaded for output.
// Async reset clears phase, config to reset values.
// ----------------------------------------------------------------------------
module fm_iq_modulator_top import fmiq_pkg::*; #(
	parameter int PHASE_BITS     = PHASE_BITS_DEF,
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [OUT_W-1:0]       i_out,
	output logic signed [OUT_W-1:0]       q_out,
	input  logic                          cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int NCELLS = (PHASE_BITS + CELL_W - 1) / CELL_W;
	localparam int ACC_W  = NCELLS * CELL_W;
	localparam int PROD_W = SAMPLE_BITS + DEV_W + 1;
	localparam int CNT_W  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCELLS - 1);

	// configuration
	logic [STEP_W-1:0] carrier_step_q;
	logic [DEV_W-1:0]  dev_scale_q;
	logic [GAIN_W-1:0] i_gain_q;
	logic [GAIN_W-1:0] q_gain_q;
	logic [OFS_W-1:0]  phase_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_step_q <= CARRIER_STEP_RST;
			dev_scale_q    <= DEV_SCALE_RST;
			i_gain_q       <= GAIN_RST;
			q_gain_q       <= GAIN_RST;
			phase_offset_q <= PHASE_OFFSET_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CARRIER_STEP:    carrier_step_q <= cfg_data[STEP_W-1:0];
				REG_DEVIATION_SCALE: dev_scale_q    <= cfg_data[DEV_W-1:0];
				REG_I_GAIN:          i_gain_q       <= cfg_data[GAIN_W-1:0];
				REG_Q_GAIN:          q_gain_q       <= cfg_data[GAIN_W-1:0];
				REG_PHASE_OFFSET:    phase_offset_q <= cfg_data[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	fmiq_state_t      state_q;
	fmiq_state_t      state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             cell_en;
	logic             add_en;
	logic             rom_en;
	logic             out_load;
	logic             in_xfer;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_INC;
			ST_INC:  state_d = ST_ACC;
			ST_ACC:  if (cnt_q == CNT_LAST) state_d = ST_ADDR;
			ST_ADDR: state_d = ST_ROM;
			ST_ROM:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_OUT;
			ST_OUT:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cell_en  = 1'b0;
		add_en   = 1'b0;
		rom_en   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_ACC: begin
				cell_en = 1'b1;
				add_en  = (cnt_q == '0);
			end
			ST_ROM:  rom_en = 1'b1;
			ST_OUT:  out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign in_xfer = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cell_en) begin
				cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// phase increment
	logic signed [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]         inc_q;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			prod_q <= sample * $signed({1'b0, dev_scale_q});
		end
		if (state_q == ST_INC) begin
			inc_q <= ACC_W'($signed(carrier_step_q)) + ACC_W'(prod_q);
		end
	end

	// accumulator cell chain
	logic [ACC_W-1:0]  phase_all;
	logic [NCELLS-1:0] carry;

	for (genvar k = 0; k < NCELLS; k++) begin : g_cell
		logic [CELL_W-1:0] addend;
		logic              cin;

		assign addend = add_en ? inc_q[k*CELL_W +: CELL_W] : '0;
		if (k == 0) begin : g_first
			assign cin = 1'b0;
		end else begin : g_next
			assign cin = carry[k-1];
		end

		fmiq_acc_cell #(
			.W(CELL_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (cell_en),
			.addend (addend),
			.cin    (cin),
			.phase  (phase_all[k*CELL_W +: CELL_W]),
			.carry  (carry[k])
		);
	end

	// sine lookup
	logic [PHASE_BITS-1:0]     phase;
	logic [PHASE_BITS-1:0]     phase_i;
	logic [SINE_ADDR_BITS-1:0] addr_i_q;
	logic [SINE_ADDR_BITS-1:0] addr_q_q;
	logic [SINE_W-1:0]         mag_i;
	logic [SINE_W-1:0]         mag_q;
	logic                      neg_i;
	logic                      neg_q;

	assign phase   = phase_all[PHASE_BITS-1:0];
	assign phase_i = phase + PHASE_BITS'(phase_offset_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			addr_i_q <= phase_i[PHASE_BITS-1 -: SINE_ADDR_BITS];
			addr_q_q <= phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
		end
	end

	fmiq_sine_rom #(
		.SINE_ADDR_BITS(SINE_ADDR_BITS)
	) u_rom (
		.clk    (clk),
		.en     (rom_en),
		.addr_a (addr_i_q),
		.addr_b (addr_q_q),
		.mag_a  (mag_i),
		.mag_b  (mag_q),
		.neg_a  (neg_i),
		.neg_b  (neg_q)
	);

	// gain, round, output register
	logic [GP_W-1:0]         gi_q;
	logic [GP_W-1:0]         gq_q;
	logic                    neg_i_q;
	logic                    neg_q_q;
	logic signed [RS_W-1:0]  p_i;
	logic signed [RS_W-1:0]  p_q;
	logic signed [OUT_W-1:0] i_out_q;
	logic signed [OUT_W-1:0] q_out_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			gi_q    <= i_gain_q * mag_i;
			gq_q    <= q_gain_q * mag_q;
			neg_i_q <= neg_i;
			neg_q_q <= neg_q;
		end
	end

	// Q output carries an extra negation
	assign p_i = neg_i_q ? -$signed({2'b00, gi_q}) : $signed({2'b00, gi_q});
	assign p_q = neg_q_q ? $signed({2'b00, gq_q}) : -$signed({2'b00, gq_q});

	always_ff @(posedge clk) begin
		if (out_load) begin
			i_out_q <= round_sat(p_i);
			q_out_q <= round_sat(p_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign i_out     = i_out_q;
	assign q_out     = q_out_q;

endmodule

@@ hw/rtl/fmiq_acc_cell.sv @@
// ----------------------------------------------------------------------------
// fmiq_acc_cell
// One slice of the phase accumulator; carry is registered and goes to the next slice per cycle while en is high.
// ----------------------------------------------------------------------------
module fmiq_acc_cell import fmiq_pkg::*; #(
	parameter int W = CELL_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] addend,
	input  logic         cin,
	output logic [W-1:0] phase,
	output logic         carry
);

	logic [W-1:0] phase_q;
	logic         carry_q;
	logic [W:0]   sum;

	assign sum = {1'b0, phase_q} + {1'b0, addend} + (W+1)'(cin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			carry_q <= 1'b0;
		end else if (en) begin
			phase_q <= sum[W-1:0];
			carry_q <= sum[W];
		end
	end

	assign phase = phase_q;
	assign carry = carry_q;

endmodule

@@ hw/rtl/fmiq_sine_rom.sv @@
// ----------------------------------------------------------------------------
// fmiq_sine_rom
// Quarter-wave sine ROM, two read ports, quadrant folding, registered output.
// ----------------------------------------------------------------------------
module fmiq_sine_rom import fmiq_pkg::*; #(
	parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [SINE_ADDR_BITS-1:0] addr_a,
	input  logic [SINE_ADDR_BITS-1:0] addr_b,
	output logic [SINE_W-1:0]         mag_a,
	output logic [SINE_W-1:0]         mag_b,
	output logic                      neg_a,
	output logic                      neg_b
);

	localparam int QUAD_BITS = SINE_ADDR_BITS - 2;
	localparam int QUAD_SIZE = 1 << QUAD_BITS;
	localparam logic [QUAD_BITS:0] QUAD_TOP = (QUAD_BITS+1)'(QUAD_SIZE);

	typedef logic [SINE_W-1:0] rom_t [QUAD_SIZE+1];

	function automatic rom_t build_rom();
		rom_t r;
		int k;
		for (k = 0; k <= QUAD_SIZE; k++) begin
			r[k] = quarter_sine(64'(k), QUAD_BITS);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [QUAD_BITS:0] idx_a;
	logic [QUAD_BITS:0] idx_b;
	logic [SINE_W-1:0]  mag_a_q;
	logic [SINE_W-1:0]  mag_b_q;
	logic               neg_a_q;
	logic               neg_b_q;

	// odd quadrants run backward
	assign idx_a = addr_a[QUAD_BITS] ? QUAD_TOP - {1'b0, addr_a[QUAD_BITS-1:0]}
	                                 : {1'b0, addr_a[QUAD_BITS-1:0]};
	assign idx_b = addr_b[QUAD_BITS] ? QUAD_TOP - {1'b0, addr_b[QUAD_BITS-1:0]}
	                                 : {1'b0, addr_b[QUAD_BITS-1:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			mag_a_q <= SINE_ROM[idx_a];
			mag_b_q <= SINE_ROM[idx_b];
			neg_a_q <= addr_a[QUAD_BITS+1];
			neg_b_q <= addr_b[QUAD_BITS+1];
		end
	end

	assign mag_a = mag_a_q;
	assign mag_b = mag_b_q;
	assign neg_a = neg_a_q;
	assign neg_b = neg_b_q;

endmodule

@@ hw/rtl/fmiq_checker.sv @@
// ----------------------------------------------------------------------------
// fmiq_checker
// Port-level checks of the FM I/Q modulator, bound to the top level.
// ----------------------------------------------------------------------------
module fmiq_checker import fmiq_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] i_out,
	input logic signed [OUT_W-1:0] q_out
);

	localparam int NCELLS = (PHASE_BITS + CELL_W - 1) / CELL_W;
	localparam int LAT    = NCELLS + 6;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(i_out) && $stable(q_out))
		else $error("result changed while stalled");

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// fixed latency into an empty output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##LAT out_valid)
		else $error("result missing after transfer");

	// a new result only at the end of an item's work
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind fm_iq_modulator_top fmiq_checker #(
	.PHASE_BITS(PHASE_BITS)
) u_fmiq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.i_out     (i_out),
	.q_out     (q_out)
);
